@@ rtl/hrkd_pkg.sv @@
// Shared constants for the HID report key-change detector.
// No dependencies; used by every module in rtl/.
`default_nettype none
package hrkd_pkg;

  // Widths of a keycode and of the modifier byte
  localparam int unsigned KEY_W = 8;
  localparam int unsigned MOD_W = 8;

  // Number of keycode slot ports on the request channel
  localparam int unsigned IN_SLOTS = 6;

  // Keycode that marks an empty slot
  localparam logic [KEY_W-1:0] KEY_NONE = '0;

  typedef logic [KEY_W-1:0] key_t;
  typedef logic [MOD_W-1:0] mod_t;

endpackage
`default_nettype wire

@@ rtl/hrkd_lane.sv @@
// One compare lane: flags a keycode that is nonzero and absent from a key list.
// Depends on hrkd_pkg.
`default_nettype none
module hrkd_lane #(
  parameter int unsigned N = 6
) (
  input  wire hrkd_pkg::key_t         code,
  input  wire hrkd_pkg::key_t [N-1:0] keys,
  output logic                        changed
);

  logic [N-1:0] match;

  // Compare against every slot of the other report in parallel
  always_comb begin
    for (int i = 0; i < N; i++) begin
      match[i] = (keys[i] == code);
    end
  end

  assign changed = (code != hrkd_pkg::KEY_NONE) && !(|match);

endmodule
`default_nettype wire

@@ rtl/hrkd_emit.sv @@
// Merge stage: holds the event mask of one report and issues one event per
// cycle, while the output is not stalled, into a registered output. Depends on hrkd_pkg.
`default_nettype none
module hrkd_emit #(
  parameter int unsigned N = 6
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // job load from the compare lanes
  input  wire logic                         ld_valid,
  input  wire logic [2*N-1:0]               ld_mask,
  input  wire hrkd_pkg::key_t [2*N-1:0]     ld_codes,
  input  wire hrkd_pkg::mod_t               ld_mods,
  output logic                              ld_ready,
  // event channel
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic                              out_is_press,
  output hrkd_pkg::key_t                    out_event_key,
  output hrkd_pkg::mod_t                    out_event_modifiers,
  output logic                              out_last_event
);

  localparam int unsigned NE = 2 * N;
  // upper half of the mask holds press events
  localparam logic [NE-1:0] PRESS_MASK = {{N{1'b1}}, {N{1'b0}}};

  logic [NE-1:0]            mask_r, mask_nxt;
  hrkd_pkg::key_t [NE-1:0]  codes_r;
  hrkd_pkg::mod_t           mods_r;
  logic                     out_valid_r, out_valid_nxt;
  logic                     press_r;
  hrkd_pkg::key_t           key_r;
  hrkd_pkg::mod_t           omods_r;
  logic                     last_r;

  logic [NE-1:0]            first_hot;
  logic [NE-1:0]            rest;
  logic                     pop;
  hrkd_pkg::key_t           sel_key;

  // Pick the lowest pending event
  assign first_hot = mask_r & (~mask_r + {{(NE-1){1'b0}}, 1'b1});
  assign rest      = mask_r & ~first_hot;
  assign pop       = (|mask_r) && (!out_valid_r || out_ready);

  always_comb begin
    sel_key = '0;
    for (int i = 0; i < NE; i++) begin
      sel_key = sel_key | (codes_r[i] & {hrkd_pkg::KEY_W{first_hot[i]}});
    end
  end

  // Take a new job once the current one drains this cycle
  assign ld_ready = (mask_r == '0) || (pop && (rest == '0));

  always_comb begin
    mask_nxt = mask_r;
    if (ld_valid && ld_ready) begin
      mask_nxt = ld_mask;
    end else if (pop) begin
      mask_nxt = rest;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Job payload and output register
  always_ff @(posedge clk) begin
    if (ld_valid && ld_ready) begin
      codes_r <= ld_codes;
      mods_r  <= ld_mods;
    end
    if (pop) begin
      press_r <= |(first_hot & PRESS_MASK);
      key_r   <= sel_key;
      omods_r <= mods_r;
      last_r  <= (rest == '0);
    end
  end

  assign out_valid           = out_valid_r;
  assign out_is_press        = press_r;
  assign out_event_key       = key_r;
  assign out_event_modifiers = omods_r;
  assign out_last_event      = last_r;

endmodule
`default_nettype wire

@@ rtl/hid_report_key_diff.sv @@
// Top level of the HID boot-keyboard report key-change detector.
// Depends on hrkd_pkg, hrkd_lane and hrkd_emit.
//
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------------
//  in      | in_valid / in_ready  | in_modifier_bits, in_slot_key_0..5
//  out     | out_valid/ out_ready | out_is_press, out_event_key,
//          |                      | out_event_modifiers, out_last_event
//
// A request is compared combinationally by 2*KEY_SLOTS lanes; the merge stage
// then issues one event per cycle while the output is not stalled. The next
// request is taken in the cycle the last event of the previous one leaves the
// job mask. The first event passes through the job mask and then the output
// register. Synchronous reset clears the kept keys and all valid state. A
// stalled output holds its event and the job.
`default_nettype none
module hid_report_key_diff #(
  parameter int unsigned KEY_SLOTS = 6
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [7:0]      in_modifier_bits,
  input  wire logic [7:0]      in_slot_key_0,
  input  wire logic [7:0]      in_slot_key_1,
  input  wire logic [7:0]      in_slot_key_2,
  input  wire logic [7:0]      in_slot_key_3,
  input  wire logic [7:0]      in_slot_key_4,
  input  wire logic [7:0]      in_slot_key_5,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic                 out_is_press,
  output logic [7:0]           out_event_key,
  output logic [7:0]           out_event_modifiers,
  output logic                 out_last_event
);

  hrkd_pkg::key_t [hrkd_pkg::IN_SLOTS-1:0] in_keys;
  hrkd_pkg::key_t [KEY_SLOTS-1:0]          fresh;
  hrkd_pkg::key_t [KEY_SLOTS-1:0]          prev_r;
  logic [2*KEY_SLOTS-1:0]                  ev_mask;
  hrkd_pkg::key_t [2*KEY_SLOTS-1:0]        ev_codes;
  logic                                    accept;

  assign in_keys = {in_slot_key_5, in_slot_key_4, in_slot_key_3,
                    in_slot_key_2, in_slot_key_1, in_slot_key_0};

  // Slots beyond the input ports read as empty
  for (genvar i = 0; i < KEY_SLOTS; i++) begin : g_fresh
    if (i < hrkd_pkg::IN_SLOTS) begin : g_port
      assign fresh[i] = in_keys[i];
    end else begin : g_empty
      assign fresh[i] = hrkd_pkg::KEY_NONE;
    end
  end

  // Release lanes check old keys, press lanes check new keys
  for (genvar i = 0; i < KEY_SLOTS; i++) begin : g_lane
    hrkd_lane #(.N(KEY_SLOTS)) u_rel (
      .code    (prev_r[i]),
      .keys    (fresh),
      .changed (ev_mask[i])
    );
    hrkd_lane #(.N(KEY_SLOTS)) u_prs (
      .code    (fresh[i]),
      .keys    (prev_r),
      .changed (ev_mask[KEY_SLOTS+i])
    );
  end

  assign ev_codes = {fresh, prev_r};
  assign accept   = in_valid && in_ready;

  // Keep the accepted report's keys for the next compare
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
    end else if (accept) begin
      prev_r <= fresh;
    end
  end

  hrkd_emit #(.N(KEY_SLOTS)) u_emit (
    .clk                 (clk),
    .rst_n               (rst_n),
    .ld_valid            (in_valid),
    .ld_mask             (ev_mask),
    .ld_codes            (ev_codes),
    .ld_mods             (in_modifier_bits),
    .ld_ready            (in_ready),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_is_press        (out_is_press),
    .out_event_key       (out_event_key),
    .out_event_modifiers (out_event_modifiers),
    .out_last_event      (out_last_event)
  );

endmodule
`default_nettype wire

@@ bench/tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for hid_report_key_diff: drives boot-keyboard requests,
// predicts release/press events in a scoreboard class and checks each event.
// Depends on rtl/hrkd_pkg.sv and rtl/hid_report_key_diff.sv.

module tb;

  localparam int unsigned NUM_SLOTS = 6;
  localparam bit KEY_PRESS = 1'b1;
  localparam bit KEY_RELEASE = 1'b0;
  localparam int unsigned IDLE_PCT = 21;
  localparam int unsigned HOLD_CYCLES = 150;
  localparam int unsigned RANDOM_REPORTS = 100;

  typedef struct packed {
    hrkd_pkg::mod_t mods;
    hrkd_pkg::key_t [hrkd_pkg::IN_SLOTS-1:0] keys;
  } report_t;

  typedef struct packed {
    bit             is_press;
    hrkd_pkg::key_t key;
    hrkd_pkg::mod_t mods;
    bit             last;
  } key_event_t;

  // Scoreboard: keeps the previous key set and the queue of expected events
  class key_event_board;
    hrkd_pkg::key_t held[NUM_SLOTS];
    key_event_t     pending[$];
    int             errors;

    function new();
      foreach (held[i]) held[i] = hrkd_pkg::KEY_NONE;
      errors = 0;
    endfunction

    function bit holds_key(hrkd_pkg::key_t set[NUM_SLOTS], hrkd_pkg::key_t code);
      foreach (set[i]) if (set[i] == code) return 1'b1;
      return 1'b0;
    endfunction

    // Expand an accepted request into releases, then presses
    function void note_report(report_t r);
      hrkd_pkg::key_t fresh[NUM_SLOTS];
      key_event_t ev;
      int first;
      first = pending.size();
      for (int i = 0; i < NUM_SLOTS; i++)
        fresh[i] = (i < hrkd_pkg::IN_SLOTS) ? r.keys[i] : hrkd_pkg::KEY_NONE;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (held[i] != hrkd_pkg::KEY_NONE && !holds_key(fresh, held[i])) begin
          ev = '{KEY_RELEASE, held[i], r.mods, 1'b0};
          pending.push_back(ev);
        end
      end
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (fresh[i] != hrkd_pkg::KEY_NONE && !holds_key(held, fresh[i])) begin
          ev = '{KEY_PRESS, fresh[i], r.mods, 1'b0};
          pending.push_back(ev);
        end
      end
      if (pending.size() > first) pending[pending.size()-1].last = 1'b1;
      held = fresh;
    endfunction

    // Compare one delivered event with the oldest expectation
    function void check_event(bit is_press, hrkd_pkg::key_t key, hrkd_pkg::mod_t mods,
                              bit last);
      key_event_t ev;
      if (pending.size() == 0) begin
        $display("%0t: unexpected event press=%0b key=%h mods=%h last=%0b",
                 $time, is_press, key, mods, last);
        errors++;
        return;
      end
      ev = pending.pop_front();
      if (is_press !== ev.is_press) begin
        $display("%0t: is_press expected %0b actual %0b", $time, ev.is_press, is_press);
        errors++;
      end
      if (key !== ev.key) begin
        $display("%0t: event_key expected %h actual %h", $time, ev.key, key);
        errors++;
      end
      if (mods !== ev.mods) begin
        $display("%0t: event_modifiers expected %h actual %h", $time, ev.mods, mods);
        errors++;
      end
      if (last !== ev.last) begin
        $display("%0t: last_event expected %0b actual %0b", $time, ev.last, last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  hrkd_pkg::mod_t in_modifier_bits = '0;
  hrkd_pkg::key_t in_slot_key_0 = '0;
  hrkd_pkg::key_t in_slot_key_1 = '0;
  hrkd_pkg::key_t in_slot_key_2 = '0;
  hrkd_pkg::key_t in_slot_key_3 = '0;
  hrkd_pkg::key_t in_slot_key_4 = '0;
  hrkd_pkg::key_t in_slot_key_5 = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_is_press;
  hrkd_pkg::key_t out_event_key;
  hrkd_pkg::mod_t out_event_modifiers;
  logic out_last_event;

  key_event_board board;
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;
  bit hold_req = 1'b0;

  hid_report_key_diff #(.KEY_SLOTS(NUM_SLOTS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_modifier_bits(in_modifier_bits),
    .in_slot_key_0(in_slot_key_0), .in_slot_key_1(in_slot_key_1),
    .in_slot_key_2(in_slot_key_2), .in_slot_key_3(in_slot_key_3),
    .in_slot_key_4(in_slot_key_4), .in_slot_key_5(in_slot_key_5),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_is_press(out_is_press), .out_event_key(out_event_key),
    .out_event_modifiers(out_event_modifiers), .out_last_event(out_last_event)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Offer one request, idling at random first; return at the accepting edge
  task automatic send_report(input report_t r);
    while (!tx_calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_modifier_bits <= r.mods;
    in_slot_key_0 <= r.keys[0];
    in_slot_key_1 <= r.keys[1];
    in_slot_key_2 <= r.keys[2];
    in_slot_key_3 <= r.keys[3];
    in_slot_key_4 <= r.keys[4];
    in_slot_key_5 <= r.keys[5];
    do @(posedge clk); while (in_ready !== 1'b1);
    board.note_report(r);
  endtask

  // Build the next random request: mostly edits of the held keys, some noise
  function automatic report_t next_report(report_t prev);
    report_t r;
    r = prev;
    if ($urandom_range(99) < 20) begin
      r.mods = hrkd_pkg::mod_t'($urandom_range(255));
      for (int i = 0; i < hrkd_pkg::IN_SLOTS; i++)
        r.keys[i] = hrkd_pkg::key_t'($urandom_range(255));
    end else begin
      if ($urandom_range(1)) r.mods = hrkd_pkg::mod_t'($urandom_range(255));
      for (int i = 0; i < hrkd_pkg::IN_SLOTS; i++) begin
        if ($urandom_range(99) < 35) begin
          case ($urandom_range(3))
            0: r.keys[i] = hrkd_pkg::KEY_NONE;
            1: r.keys[i] = hrkd_pkg::key_t'($urandom_range(11, 4));
            default: r.keys[i] = hrkd_pkg::key_t'($urandom_range(255, 1));
          endcase
        end
      end
    end
    return r;
  endfunction

  // Receiver: check delivered events, stall at random, honor one long hold-off
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid === 1'b1 && out_ready)
        board.check_event(out_is_press, out_event_key, out_event_modifiers, out_last_event);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= rx_calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Watchdog
  initial begin
    #400000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    report_t directed[$];
    report_t r;
    int waited;
    board = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed requests: empty, modifier-only, full slots, extreme codes,
    // reordering, repeated codes, moved keys and full release
    directed.push_back({8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
    directed.push_back({8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
    directed.push_back({8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h04});
    directed.push_back({8'h00, 8'h09, 8'h08, 8'h07, 8'h06, 8'h05, 8'h04});
    directed.push_back({8'hAA, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09});
    directed.push_back({8'h55, 8'h55, 8'h7F, 8'h01, 8'h80, 8'hFE, 8'hFF});
    directed.push_back({8'h55, 8'h00, 8'h7F, 8'h01, 8'h80, 8'hFE, 8'hFF});
    directed.push_back({8'h11, 8'h00, 8'h00, 8'h00, 8'h00, 8'h2A, 8'h2A});
    directed.push_back({8'h22, 8'h00, 8'h00, 8'h2A, 8'h2A, 8'h00, 8'h2A});
    directed.push_back({8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
    directed.push_back({8'h01, 8'h39, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
    directed.push_back({8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h39});
    directed.push_back({8'h08, 8'h00, 8'h00, 8'h00, 8'h00, 8'h04, 8'hE0});
    directed.push_back({8'h40, 8'h06, 8'h05, 8'h04, 8'h03, 8'h02, 8'h01});
    directed.push_back({8'h80, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
    directed.push_back({8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
    foreach (directed[i]) send_report(directed[i]);

    // Random requests with a calm stretch on each side and one long hold-off
    r = directed[directed.size()-1];
    for (int n = 0; n < RANDOM_REPORTS; n++) begin
      if (n == 10) hold_req = 1'b1;
      tx_calm = (n >= 40 && n < 60);
      rx_calm = (n >= 45 && n < 65);
      r = next_report(r);
      send_report(r);
    end
    in_valid <= 1'b0;
    tx_calm = 1'b0;
    rx_calm = 1'b0;

    // Drain outstanding events, then keep watching for strays
    waited = 0;
    while (board.pending.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (40) @(posedge clk);
    foreach (board.pending[i]) begin
      $display("%0t: missing event press=%0b key=%h mods=%h last=%0b", $time,
               board.pending[i].is_press, board.pending[i].key,
               board.pending[i].mods, board.pending[i].last);
      board.errors++;
    end

    if (board.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
